// File: src/spq_pkg.sv
// shared types and constants for the sorted priority queue core
// no dependencies; imported by every module of the block
package spq_pkg;

   // default number of slots in the queue
   localparam int DEPTH_DEFAULT = 16;

   // payload field widths
   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_REPORT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_op;
      logic exec;
      logic report;
   } spq_ctrl_type;

endpackage

// File: src/spq_controller.sv
// controller state machine of the sorted priority queue core
// depends on spq_pkg; drives spq_datapath through spq_ctrl_type commands
module spq_controller
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output spq_ctrl_type ctrl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      report_go;

   // result register may be loaded when empty or being drained this cycle
   assign report_go = (state_ff == S_REPORT) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (report_go) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and commands
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      ctrl.load_op = (state_ff == S_IDLE) && req_tvalid;
      ctrl.exec    = (state_ff == S_EXEC);
      ctrl.report  = report_go;
      rsp_tvalid   = rsp_valid_ff;
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (report_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted transfer is always executed in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted transfer not executed");

   // a pending result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !ctrl.report)
      else $error("pending result overwritten");

   // execution always leads to the report state
   a_exec_report: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_REPORT))
      else $error("execution not followed by report");

endmodule

// File: src/spq_datapath.sv
// datapath of the sorted priority queue: row of compare-and-shift slots,
// entry count, operand and result registers; depends on spq_pkg
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  spq_ctrl_type               ctrl,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_head_value,
   output logic signed [VALUE_W-1:0]  rsp_tail_value,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // operand registers
   cmd_type                   op_cmd_ff;
   logic signed [VALUE_W-1:0] op_value_ff;

   // slot row and fill count
   logic signed [VALUE_W-1:0] entry_ff [DEPTH];
   logic signed [VALUE_W-1:0] entry_in [DEPTH];
   logic signed [VALUE_W-1:0] ins_val  [DEPTH];
   logic signed [VALUE_W-1:0] rem_val  [DEPTH];
   logic [CNT_W-1:0]          count_ff, count_in;
   status_type                status_ff, status_in;

   logic [DEPTH-1:0] slot_valid;
   logic [DEPTH-1:0] slot_gt;
   logic [DEPTH-1:0] slot_eq;
   logic             found;
   logic             full_now;

   // per-slot compares against the operand
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         slot_valid[k] = (CNT_W'(k) < count_ff);
         slot_gt[k]    = slot_valid[k] && (entry_ff[k] > op_value_ff);
         slot_eq[k]    = slot_valid[k] && (entry_ff[k] == op_value_ff);
      end
   end

   assign found    = |slot_eq;
   assign full_now = (count_ff >= CNT_W'(DEPTH));

   // insert and remove candidates for every slot
   // entries are sorted, so the greater-than flags form a prefix: slots past
   // it shift down on insert, and on remove the first match and everything
   // after it pull up from the next slot
   for (genvar k = 0; k < DEPTH; k++) begin : g_slot
      if (k == 0) begin : g_first
         assign ins_val[k] = slot_gt[k] ? entry_ff[k] : op_value_ff;
      end else begin : g_rest
         assign ins_val[k] = slot_gt[k]   ? entry_ff[k] :
                             slot_gt[k-1] ? op_value_ff : entry_ff[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign rem_val[k] = entry_ff[k];
      end else begin : g_inner
         assign rem_val[k] = slot_gt[k] ? entry_ff[k] : entry_ff[k+1];
      end
   end

   // command execution
   always_comb begin
      entry_in  = entry_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (ctrl.exec) begin
         status_in = ST_DONE;
         unique case (op_cmd_ff)
            CMD_INSERT: begin
               if (full_now) begin
                  status_in = ST_FULL;
               end else begin
                  entry_in = ins_val;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (found) begin
                  entry_in = rem_val;
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            CMD_NOP: begin
               status_in = ST_DONE;
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // slots, operand and status
   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      status_ff <= status_in;
      if (ctrl.load_op) begin
         op_cmd_ff   <= cmd_type'(req_cmd);
         op_value_ff <= req_value;
      end
   end

   // view of the queue for the result
   logic signed [VALUE_W-1:0] tail_sel;
   logic                      empty_now;

   assign empty_now = (count_ff == '0);

   always_comb begin
      tail_sel = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (count_ff == CNT_W'(k + 1)) tail_sel = entry_ff[k];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.report) begin
         rsp_status      <= status_ff;
         rsp_head_value  <= empty_now ? '0 : entry_ff[0];
         rsp_tail_value  <= tail_sel;
         rsp_entry_count <= COUNT_W'(count_ff);
         rsp_is_empty    <= empty_now;
         rsp_is_full     <= (count_ff == CNT_W'(DEPTH));
      end
   end

   // fill count never passes the number of slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // clear empties the queue
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (ctrl.exec && op_cmd_ff == CMD_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries");

   // a dropped insert or a failed remove leaves the count alone
   a_fail_stable: assert property (@(posedge clock) disable iff (reset)
      (ctrl.exec && status_in != ST_DONE) |=> $stable(count_ff))
      else $error("failed command changed the count");

endmodule

// File: src/sorted_priority_queue_core.sv
// Sorted priority queue core, top level.
// Depends on spq_pkg, spq_controller and spq_datapath.
//
// Usage:
//   Commands arrive on the req_ stream: insert a signed value, remove the
//   first stored entry equal to a value, or clear the queue (code 3 does
//   nothing). Entries are kept in descending order in a row of slots that
//   compare against the operand in parallel and shift up or down as one.
//   Every command returns exactly one transfer on the rsp_ stream with a
//   status (done, insert dropped because full, remove not found) and the
//   queue after the command: head (largest), tail (smallest), count and
//   the empty and full flags. Head and tail read zero when empty.
//   After the command transfer the operand is registered, the slots are
//   updated, and then the result register is loaded.
//   The core takes no new command until the controller's capture, execute
//   and report sequence for the previous one is done.
//   A new command is taken while an earlier result still waits; if the
//   receiver stalls, the core holds in the report step until the result
//   register is free, and holds req_tready low meanwhile.
//   Reset empties the queue at once; the slot contents are not cleared.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cmd[1:0], value[33:2], zero pad
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // status[1:0], head_value[33:2],
                                    // tail_value[65:34], entry_count[70:66],
                                    // is_empty[71], is_full[72], zero pad
);

   spq_ctrl_type              ctrl;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_head_value;
   logic signed [VALUE_W-1:0] rsp_tail_value;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;

   // sequencing of transfers
   spq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   // slots and result registers
   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_cmd         (req_tdata[1:0]),
      .req_value       (req_tdata[33:2]),
      .rsp_status      (rsp_status),
      .rsp_head_value  (rsp_head_value),
      .rsp_tail_value  (rsp_tail_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   // result packing
   assign rsp_tdata = {7'b0, rsp_is_full, rsp_is_empty, rsp_entry_count,
                       rsp_tail_value, rsp_head_value, rsp_status};

endmodule
